### rtl/core/plt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the peer liveness table.
package plt_pkg;

  localparam int unsigned EntriesDefault = 8;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned TimeoutW       = 16;
  localparam int unsigned SlotW          = 3;
  localparam int unsigned PaddrW         = 3;
  localparam int unsigned PdataW         = 32;

  localparam logic [TimeoutW-1:0] ExpiryReset = 16'd10;

  // Register index, taken from paddr[PaddrW-1:2].
  localparam logic [PaddrW-3:0] RegExpiry = 1'b0;

  localparam logic KindMark  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [1:0] {
    OcQuery   = 2'd0,
    OcRefresh = 2'd1,
    OcReuse   = 2'd2,
    OcEvict   = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StCommit,
    StResult
  } state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic eval;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic query;
    logic out_free;
  } status_t;

endpackage

### rtl/core/plt_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the peer liveness table.
interface plt_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] peer_addr;
  logic [31:0] now_seconds;

  modport source (output valid, output kind, output peer_addr, output now_seconds,
                  input ready);
  modport sink (input valid, input kind, input peer_addr, input now_seconds,
                output ready);
endinterface

interface plt_rsp_if;
  logic       valid;
  logic       ready;
  logic       alive;
  logic [2:0] slot;
  logic [1:0] outcome;

  modport source (output valid, output alive, output slot, output outcome,
                  input ready);
  modport sink (input valid, input alive, input slot, input outcome,
                output ready);
endinterface

### rtl/core/plt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences the table scan one entry per cycle.
module plt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  plt_pkg::status_t status_i,
  output plt_pkg::cmd_t    cmd_o
);
  import plt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StScan;
      end
      StScan: begin
        cmd_o.eval = 1'b1;
        // a mark stops at the first matching entry
        if (!status_i.query && status_i.match) begin
          state_d = StResult;
        end else if (status_i.last) begin
          state_d = status_i.query ? StResult : StCommit;
        end else begin
          cmd_o.read = 1'b1;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StResult;
      end
      StResult: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  a_load_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == StRead))
    else $error("accepted beat did not start a table read");

  a_scan_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ($past(state_q) == StRead || $past(state_q) == StScan))
    else $error("scan entered without a pending read");

  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCommit) |-> ($past(state_q) == StScan && !$past(status_i.query)))
    else $error("commit not preceded by a mark scan");

endmodule

### rtl/core/plt_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memories, scan index, age compare, victim tracking, result register.
module plt_datapath #(
  parameter int unsigned Entries = plt_pkg::EntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plt_pkg::cmd_t                 cmd_i,
  output plt_pkg::status_t              status_o,
  input  logic [plt_pkg::TimeoutW-1:0]  expiry_i,
  input  logic                          kind_i,
  input  logic [plt_pkg::AddrW-1:0]     peer_addr_i,
  input  logic [plt_pkg::TimeW-1:0]     now_seconds_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic                          alive_o,
  output logic [plt_pkg::SlotW-1:0]     slot_o,
  output logic [1:0]                    outcome_o
);
  import plt_pkg::*;

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned ExtW = IdxW + SlotW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  logic [AddrW-1:0] addr_mem [Entries];
  logic [TimeW-1:0] time_mem [Entries];
  logic [Entries-1:0] addr_vld_q;
  logic [Entries-1:0] time_vld_q;

  logic             kind_q;
  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] now_q;
  logic [IdxW-1:0]  idx_q;

  logic [AddrW-1:0] rd_addr_q;
  logic [TimeW-1:0] rd_time_q;
  logic             rd_avld_q;
  logic             rd_tvld_q;

  logic             alive_q;
  logic             dead_vld_q;
  logic [IdxW-1:0]  dead_idx_q;
  logic             old_vld_q;
  logic [IdxW-1:0]  old_idx_q;
  logic [TimeW-1:0] old_time_q;
  logic [IdxW-1:0]  res_slot_q;
  outcome_e         res_oc_q;

  logic             out_vld_q;
  logic             out_alive_q;
  logic [SlotW-1:0] out_slot_q;
  outcome_e         out_oc_q;

  logic [AddrW-1:0] cur_addr;
  logic [TimeW-1:0] cur_time;
  logic [TimeW-1:0] age;
  logic [TimeW-1:0] span;
  logic [TimeW-1:0] tmo;
  logic             match;
  logic             expired;
  logic             fresh;
  logic             older;
  logic [IdxW-1:0]  rd_idx;
  logic [IdxW-1:0]  tgt_idx;
  outcome_e         tgt_oc;
  logic [ExtW-1:0]  slot_ext;

  logic             a_we;
  logic [IdxW-1:0]  a_widx;
  logic [AddrW-1:0] a_wdata;
  logic             t_we;
  logic [IdxW-1:0]  t_widx;
  logic [TimeW-1:0] t_wdata;

  // never-written entries read as zero
  assign cur_addr = rd_avld_q ? rd_addr_q : '0;
  assign cur_time = rd_tvld_q ? rd_time_q : '0;

  assign tmo     = {{(TimeW - TimeoutW){1'b0}}, expiry_i};
  assign age     = now_q - cur_time;
  assign span    = cur_time - old_time_q;
  assign match   = (cur_addr == addr_q);
  assign expired = !age[TimeW-1] && (age > tmo);
  assign fresh   = age[TimeW-1] || (age < tmo);
  assign older   = !old_vld_q || span[TimeW-1];

  // during the scan, prefetch the entry after the one being evaluated
  assign rd_idx = cmd_i.eval ? idx_q + IdxW'(1) : idx_q;

  assign tgt_idx = dead_vld_q ? dead_idx_q : (old_vld_q ? old_idx_q : '0);
  assign tgt_oc  = dead_vld_q ? OcReuse : OcEvict;

  always_comb begin
    a_we    = 1'b0;
    a_widx  = idx_q;
    a_wdata = '0;
    t_we    = 1'b0;
    t_widx  = idx_q;
    t_wdata = now_q;
    if (cmd_i.eval && kind_q == KindMark) begin
      if (match) begin
        t_we = 1'b1;
      end else if (expired) begin
        a_we = 1'b1;
      end
    end
    if (cmd_i.commit) begin
      a_we    = 1'b1;
      a_widx  = tgt_idx;
      a_wdata = addr_q;
      t_we    = 1'b1;
      t_widx  = tgt_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      addr_mem[a_widx] <= a_wdata;
    end
    if (t_we) begin
      time_mem[t_widx] <= t_wdata;
    end
    if (cmd_i.read) begin
      rd_addr_q <= addr_mem[rd_idx];
      rd_time_q <= time_mem[rd_idx];
      rd_avld_q <= addr_vld_q[rd_idx];
      rd_tvld_q <= time_vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_vld_q <= '0;
      time_vld_q <= '0;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (a_we) begin
        addr_vld_q[a_widx] <= 1'b1;
      end
      if (t_we) begin
        time_vld_q[t_widx] <= 1'b1;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.eval) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign slot_ext = ExtW'(res_slot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      addr_q     <= peer_addr_i;
      now_q      <= now_seconds_i;
      alive_q    <= 1'b0;
      dead_vld_q <= 1'b0;
      old_vld_q  <= 1'b0;
      res_slot_q <= '0;
      res_oc_q   <= OcQuery;
    end
    if (cmd_i.eval) begin
      if (kind_q == KindQuery) begin
        if (match && fresh) begin
          alive_q <= 1'b1;
        end
      end else if (match) begin
        res_slot_q <= idx_q;
        res_oc_q   <= OcRefresh;
      end else if (expired) begin
        dead_vld_q <= 1'b1;
        dead_idx_q <= idx_q;
      end else if (older) begin
        old_vld_q  <= 1'b1;
        old_idx_q  <= idx_q;
        old_time_q <= cur_time;
      end
    end
    if (cmd_i.commit) begin
      res_slot_q <= tgt_idx;
      res_oc_q   <= tgt_oc;
    end
    if (cmd_i.emit) begin
      out_alive_q <= alive_q;
      out_slot_q  <= slot_ext[SlotW-1:0];
      out_oc_q    <= res_oc_q;
    end
  end

  assign status_o.match    = match;
  assign status_o.last     = (idx_q == LastIdx);
  assign status_o.query    = (kind_q == KindQuery);
  assign status_o.out_free = !out_vld_q || rsp_ready_i;

  assign rsp_valid_o = out_vld_q;
  assign alive_o     = out_alive_q;
  assign slot_o      = out_slot_q;
  assign outcome_o   = out_oc_q;

  a_commit_is_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (kind_q == KindMark && !$past(match)))
    else $error("table commit for a query or after a match");

endmodule

### rtl/core/peer_liveness_table_core.sv
`timescale 1ns / 1ps
// Top level of the peer liveness table: config register, controller and datapath.
//
// Request beats (req_i) carry kind, peer_addr and now_seconds; each produces one
// response beat (rsp_o) with alive, slot and outcome. A mark refreshes the first
// matching entry, clears expired entries ahead of it, and otherwise writes the
// address into the last expired entry or the oldest live one. A query reports a
// matching entry younger than the timeout register.
// The table is scanned one entry per cycle through a single read port with
// registered read data: each request is loaded, the entries are read and
// evaluated in turn, a mark that misses commits its victim entry, and the result
// goes to the response register. A mark that hits stops at the matching entry.
// The next request is accepted once the block is back in idle, while the last
// response may still wait in the output register.
// When the receiver stalls, the block holds the response and finishes at most
// one more item, which then waits for the output register to drain.
// Reset clears the entry valid bits (all entries read as zero address and time)
// and sets the timeout to 10. The user writes the timeout over the APB port at
// byte address 0 only while the block is idle; the block does not enforce this.
module peer_liveness_table_core #(
  parameter int unsigned ENTRIES = plt_pkg::EntriesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  plt_req_if.sink                     req_i,
  plt_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plt_pkg::PaddrW-1:0]  paddr,
  input  logic [plt_pkg::PdataW-1:0]  pwdata,
  output logic [plt_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import plt_pkg::*;

  logic [TimeoutW-1:0] expiry_q;
  logic [PaddrW-3:0]   reg_idx;
  logic                cfg_we;
  cmd_t                cmd;
  status_t             status;
  logic                req_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == RegExpiry);
  assign prdata  = (reg_idx == RegExpiry) ?
                   {{(PdataW - TimeoutW){1'b0}}, expiry_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ExpiryReset;
    end else if (cfg_we) begin
      expiry_q <= pwdata[TimeoutW-1:0];
    end
  end

  assign req_i.ready = req_ready;

  plt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plt_datapath #(
    .Entries (ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .expiry_i       (expiry_q),
    .kind_i         (req_i.kind),
    .peer_addr_i    (req_i.peer_addr),
    .now_seconds_i  (req_i.now_seconds),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .alive_o        (rsp_o.alive),
    .slot_o         (rsp_o.slot),
    .outcome_o      (rsp_o.outcome)
  );

endmodule
